FILE: sv/pfa_pkg.sv
// ----------------------------------------------------------------------------
// pfa_pkg
// Shared widths, action and mode codes, register indexes and the command and
// status structs that join the allocator controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package pfa_pkg;

	// Field widths of the item, result and configuration channels.
	localparam int ACTION_W      = 2;
	localparam int SLOT_INDEX_W  = 4;
	localparam int AMOUNT_W      = 16;
	localparam int SLOT_NUMBER_W = 5;
	localparam int LEFT_OVER_W   = 16;
	localparam int FIT_MODE_W    = 2;
	localparam int SLOT_COUNT_W  = 5;
	localparam int CFG_INDEX_W   = 1;
	localparam int CFG_DATA_W    = 5;

	// Item actions.
	localparam logic [ACTION_W-1:0] ACT_LOAD    = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_ALLOC   = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_RESTORE = 2'd2;

	// Placement modes; any other code behaves as first fit.
	localparam logic [FIT_MODE_W-1:0] MODE_FIRST = 2'd0;
	localparam logic [FIT_MODE_W-1:0] MODE_BEST  = 2'd1;
	localparam logic [FIT_MODE_W-1:0] MODE_WORST = 2'd2;

	// Configuration register indexes.
	localparam logic [CFG_INDEX_W-1:0] REG_FIT_MODE   = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_SLOT_COUNT = 1'd1;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;   // latch the accepted item, clear scan state
		logic rd_issue;  // read the slot at the scan counter, advance it
		logic finish;    // commit the item's write and load the result
	} pfa_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic used_zero; // no slots in use
		logic last;      // scan counter sits on the last slot to visit
		logic out_free;  // result register can take a new result
	} pfa_status_t;

endpackage

`default_nettype wire

FILE: sv/pfa_if.sv
// ----------------------------------------------------------------------------
// pfa_if
// Valid/ready channels for allocator items and allocator results.
// ----------------------------------------------------------------------------
`default_nettype none

interface pfa_item_if;
	logic                               valid;
	logic                               ready;
	logic [pfa_pkg::ACTION_W-1:0]       action;
	logic [pfa_pkg::SLOT_INDEX_W-1:0]   slot_index;
	logic [pfa_pkg::AMOUNT_W-1:0]       amount;

	modport source (output valid, action, slot_index, amount, input ready);
	modport sink (input valid, action, slot_index, amount, output ready);
endinterface

interface pfa_result_if;
	logic                               valid;
	logic                               ready;
	logic [pfa_pkg::SLOT_NUMBER_W-1:0]  slot_number;
	logic [pfa_pkg::LEFT_OVER_W-1:0]    left_over;

	modport source (output valid, slot_number, left_over, input ready);
	modport sink (input valid, slot_number, left_over, output ready);
endinterface

`default_nettype wire

FILE: sv/pfa_ctrl.sv
// ----------------------------------------------------------------------------
// pfa_ctrl
// Controller of the allocator: accepts one item at a time, steps the slot
// scan and commits the item once the result register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module pfa_ctrl (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         req_valid,
	output logic                              req_ready,
	input  wire logic [pfa_pkg::ACTION_W-1:0] action,
	input  wire pfa_pkg::pfa_status_t         status,
	output pfa_pkg::pfa_cmd_t                 cmd
);
	import pfa_pkg::*;

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_SCAN  = 2'd1;
	localparam logic [1:0] S_DRAIN = 2'd2;
	localparam logic [1:0] S_FIN   = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_next;
	logic       accept;

	assign req_ready = (state_q == S_IDLE);
	assign accept    = req_valid && req_ready;

	// Next state and commands.
	always_comb begin
		state_next   = state_q;
		cmd.capture  = 1'b0;
		cmd.rd_issue = 1'b0;
		cmd.finish   = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd.capture = 1'b1;
					if (action == ACT_RESTORE ||
						(action == ACT_ALLOC && !status.used_zero)) begin
						state_next = S_SCAN;
					end else begin
						state_next = S_FIN;
					end
				end
			end
			S_SCAN: begin
				cmd.rd_issue = 1'b1;
				if (status.last) begin
					state_next = S_DRAIN;
				end
			end
			S_DRAIN: begin
				// The last slot read is evaluated in this cycle.
				state_next = S_FIN;
			end
			S_FIN: begin
				if (status.out_free) begin
					cmd.finish = 1'b1;
					state_next = S_IDLE;
				end
			end
			default: begin
				state_next = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

endmodule

`default_nettype wire

FILE: sv/pfa_datapath.sv
// ----------------------------------------------------------------------------
// pfa_datapath
// Slot tables, configuration registers, scan counter, fit compare and the
// result register of the allocator.
// ----------------------------------------------------------------------------
`default_nettype none

module pfa_datapath #(
	parameter int SLOTS     = 16,
	parameter int SIZE_BITS = 16
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire pfa_pkg::pfa_cmd_t                   cmd,
	output pfa_pkg::pfa_status_t                     status,
	input  wire logic                                cfg_write,
	input  wire logic [pfa_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  wire logic [pfa_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  wire logic [pfa_pkg::ACTION_W-1:0]        action,
	input  wire logic [pfa_pkg::SLOT_INDEX_W-1:0]    slot_index,
	input  wire logic [pfa_pkg::AMOUNT_W-1:0]        amount,
	output logic                                     resp_valid,
	input  wire logic                                resp_ready,
	output logic [pfa_pkg::SLOT_NUMBER_W-1:0]        slot_number,
	output logic [pfa_pkg::LEFT_OVER_W-1:0]          left_over
);
	import pfa_pkg::*;

	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNT_W = $clog2(SLOTS + 1);

	// Configuration registers.
	logic [FIT_MODE_W-1:0]   fit_mode_q;
	logic [SLOT_COUNT_W-1:0] slot_count_q;

	// Captured item.
	logic [ACTION_W-1:0]     action_q;
	logic [SLOT_INDEX_W-1:0] slot_index_q;
	logic [SIZE_BITS-1:0]    amount_q;

	// Slot tables with per-entry written flags; unwritten entries read as zero.
	logic [SIZE_BITS-1:0] rem_mem  [SLOTS];
	logic [SIZE_BITS-1:0] orig_mem [SLOTS];
	logic [SLOTS-1:0]     rem_vld_q;
	logic [SLOTS-1:0]     orig_vld_q;

	// Scan counter and read stage.
	logic [CNT_W-1:0]     cnt_q;
	logic [IDX_W-1:0]     rd_addr;
	logic                 rd_vld_s1;
	logic [IDX_W-1:0]     rd_idx_s1;
	logic [SIZE_BITS-1:0] rem_rd_s1;
	logic [SIZE_BITS-1:0] orig_rd_s1;
	logic                 rem_hit_s1;
	logic                 orig_hit_s1;

	// Best candidate so far.
	logic                 found_q;
	logic [IDX_W-1:0]     pick_q;
	logic [SIZE_BITS-1:0] best_q;

	// Result register.
	logic                     out_valid_q;
	logic [SLOT_NUMBER_W-1:0] slot_number_q;
	logic [LEFT_OVER_W-1:0]   left_over_q;

	logic [CNT_W-1:0]     used;
	logic [CNT_W-1:0]     limit;
	logic [SIZE_BITS-1:0] space;
	logic [SIZE_BITS-1:0] orig_val;
	logic                 take;
	logic                 load_ok;
	logic                 alloc_hit;
	logic                 rem_we;
	logic [IDX_W-1:0]     rem_wa;
	logic [SIZE_BITS-1:0] rem_wd;
	logic                 orig_we;
	logic [IDX_W-1:0]     load_addr;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fit_mode_q   <= MODE_FIRST;
			slot_count_q <= '0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_FIT_MODE:   fit_mode_q   <= cfg_data[FIT_MODE_W-1:0];
				REG_SLOT_COUNT: slot_count_q <= cfg_data[SLOT_COUNT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Slots in use, clamped to the table size, and the scan limit.
	always_comb begin
		if (32'(slot_count_q) > SLOTS) begin
			used = CNT_W'(SLOTS);
		end else begin
			used = CNT_W'(slot_count_q);
		end
		limit = (action_q == ACT_RESTORE) ? CNT_W'(SLOTS) : used;
	end

	assign status.used_zero = (used == '0);
	assign status.last      = (cnt_q == CNT_W'(limit - 1'b1));
	assign status.out_free  = !out_valid_q || resp_ready;

	// Item capture and scan counter.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			action_q     <= action;
			slot_index_q <= slot_index;
			amount_q     <= SIZE_BITS'(amount);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= cmd.rd_issue;
			if (cmd.capture) begin
				cnt_q <= '0;
			end else if (cmd.rd_issue) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	assign rd_addr = cnt_q[IDX_W-1:0];

	// Registered table reads.
	always_ff @(posedge clk) begin
		rd_idx_s1   <= rd_addr;
		rem_rd_s1   <= rem_mem[rd_addr];
		orig_rd_s1  <= orig_mem[rd_addr];
		rem_hit_s1  <= rem_vld_q[rd_addr];
		orig_hit_s1 <= orig_vld_q[rd_addr];
	end

	assign space    = rem_hit_s1 ? rem_rd_s1 : '0;
	assign orig_val = orig_hit_s1 ? orig_rd_s1 : '0;

	// Fit compare; ties keep the earlier, lower slot.
	always_comb begin
		take = 1'b0;
		if (rd_vld_s1 && action_q == ACT_ALLOC && space >= amount_q) begin
			if (!found_q) begin
				take = 1'b1;
			end else begin
				case (fit_mode_q)
					MODE_BEST:  take = (space < best_q);
					MODE_WORST: take = (space > best_q);
					default:    take = 1'b0;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (cmd.capture) begin
			found_q <= 1'b0;
		end else if (take) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			pick_q <= rd_idx_s1;
			best_q <= space;
		end
	end

	// Table write selection: commit at finish, or copy during a restore sweep.
	assign load_ok   = (32'(slot_index_q) < SLOTS);
	assign load_addr = IDX_W'(slot_index_q);
	assign alloc_hit = (action_q == ACT_ALLOC) && found_q;

	always_comb begin
		rem_we  = 1'b0;
		rem_wa  = rd_idx_s1;
		rem_wd  = orig_val;
		orig_we = 1'b0;
		if (cmd.finish && alloc_hit) begin
			rem_we = 1'b1;
			rem_wa = pick_q;
			rem_wd = best_q - amount_q;
		end else if (cmd.finish && action_q == ACT_LOAD && load_ok) begin
			rem_we  = 1'b1;
			rem_wa  = load_addr;
			rem_wd  = amount_q;
			orig_we = 1'b1;
		end else if (rd_vld_s1 && action_q == ACT_RESTORE) begin
			rem_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (rem_we) begin
			rem_mem[rem_wa] <= rem_wd;
		end
		if (orig_we) begin
			orig_mem[load_addr] <= amount_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_vld_q  <= '0;
			orig_vld_q <= '0;
		end else begin
			if (rem_we) begin
				rem_vld_q[rem_wa] <= 1'b1;
			end
			if (orig_we) begin
				orig_vld_q[load_addr] <= 1'b1;
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (resp_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			if (alloc_hit) begin
				slot_number_q <= SLOT_NUMBER_W'(32'(pick_q) + 32'd1);
				left_over_q   <= LEFT_OVER_W'(best_q - amount_q);
			end else begin
				slot_number_q <= '0;
				left_over_q   <= '0;
			end
		end
	end

	assign resp_valid  = out_valid_q;
	assign slot_number = slot_number_q;
	assign left_over   = left_over_q;

endmodule

`default_nettype wire

FILE: sv/partition_fit_allocator_core.sv
// An allocate scans the slots in use, where used is slot_count clamped to SLOTS,
// one slot per cycle through the table read port; a restore sweeps all SLOTS slots.
// A load, another action or an allocate with no slots in use skips the scan. Each item
// finishes once the result register is free; one item is in work at a time.
// Reset clears configuration, control state and written flags; all slots read as zero.
// ----------------------------------------------------------------------------
// partition_fit_allocator_core
// Fixed-partition allocator with first-, best- and worst-fit placement.
// ----------------------------------------------------------------------------
`default_nettype none

module partition_fit_allocator_core #(
	parameter int SLOTS     = 16,
	parameter int SIZE_BITS = 16
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_write,
	input  wire logic [pfa_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [pfa_pkg::CFG_DATA_W-1:0]  cfg_data,
	pfa_item_if.sink                             request,
	pfa_result_if.source                         response
);
	import pfa_pkg::*;

	pfa_cmd_t    cmd;
	pfa_status_t status;

	pfa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (request.valid),
		.req_ready (request.ready),
		.action    (request.action),
		.status    (status),
		.cmd       (cmd)
	);

	pfa_datapath #(
		.SLOTS     (SLOTS),
		.SIZE_BITS (SIZE_BITS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.cfg_write   (cfg_write),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.action      (request.action),
		.slot_index  (request.slot_index),
		.amount      (request.amount),
		.resp_valid  (response.valid),
		.resp_ready  (response.ready),
		.slot_number (response.slot_number),
		.left_over   (response.left_over)
	);

endmodule

`default_nettype wire

FILE: sv/pfa_checker.sv
// ----------------------------------------------------------------------------
// pfa_checker
// Port-level checks on the allocator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module pfa_checker (
	input wire logic                                clk,
	input wire logic                                arst_n,
	input wire logic                                req_valid,
	input wire logic                                req_ready,
	input wire logic                                resp_valid,
	input wire logic                                resp_ready,
	input wire logic [pfa_pkg::SLOT_NUMBER_W-1:0]   slot_number,
	input wire logic [pfa_pkg::LEFT_OVER_W-1:0]     left_over
);
	import pfa_pkg::*;

	// One item at a time: an accepted item closes the input side.
	assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("input ready while an item is in work");

	// No result can appear in the cycle right after an item is taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !$rose(resp_valid))
		else $error("result appeared one cycle after accept");

	// A result without a slot carries no left-over space.
	assert property (@(posedge clk) disable iff (!arst_n)
		resp_valid && slot_number == '0 |-> left_over == '0)
		else $error("left-over space without a chosen slot");

	// A stalled result holds.
	assert property (@(posedge clk) disable iff (!arst_n)
		resp_valid && !resp_ready |=> resp_valid && $stable(slot_number) &&
			$stable(left_over))
		else $error("stalled result changed");

endmodule

bind partition_fit_allocator_core pfa_checker u_pfa_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_valid   (request.valid),
	.req_ready   (request.ready),
	.resp_valid  (response.valid),
	.resp_ready  (response.ready),
	.slot_number (response.slot_number),
	.left_over   (response.left_over)
);

`default_nettype wire
